/* hw/rtl/pa_pkg.sv */
// primitive assembly package: primitive mode and kind codes, register indexes
// and field widths shared by the top level and its checker
// no dependencies
package pa_pkg;

    localparam int INDEX_BITS_DEFAULT = 32;
    localparam int CORNER_W           = 32;
    localparam int COUNT_W            = 32;
    localparam int CFG_IDX_W          = 1;
    localparam int CFG_DATA_W         = 32;
    localparam int MODE_W             = 4;
    localparam int KIND_W             = 2;
    localparam int PHASE_W            = 4;
    localparam int WARM_W             = 2;
    localparam int DATA_W             = 3 * CORNER_W;

    localparam logic [CFG_IDX_W-1:0] REG_PRIM_MODE    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT = 1'd1;

    localparam logic [PHASE_W-1:0] PHASE_WRAP = 4'd11;

    typedef enum logic [MODE_W-1:0] {
        MODE_POINTS     = 4'd0,
        MODE_LINES      = 4'd1,
        MODE_LINE_LOOP  = 4'd2,
        MODE_LINE_STRIP = 4'd3,
        MODE_TRIS       = 4'd4,
        MODE_TRI_STRIP  = 4'd5,
        MODE_TRI_FAN    = 4'd6,
        MODE_QUADS      = 4'd7,
        MODE_QUAD_STRIP = 4'd8,
        MODE_POLYGON    = 4'd9
    } mode_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_POINT    = 2'd0,
        KIND_LINE     = 2'd1,
        KIND_TRIANGLE = 2'd2
    } kind_t;

endpackage

/* hw/rtl/primitive_assembly.sv */
// primitive assembly top level: turns a vertex index stream into point, line
// and triangle index tuples; depends on pa_pkg
//
// results: each one is registered into the result queue and offered from its head
// throughput: one index per cycle while each item makes at most one result
// and the master side takes every result; the master side moves one result
// per cycle, so a two-result item holds back input through the three-entry result queue
// reset: rst_n clears the configuration registers and draw state and empties the result queue at once
module primitive_assembly #(
    parameter int INDEX_BITS = pa_pkg::INDEX_BITS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [pa_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [pa_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [pa_pkg::CORNER_W-1:0]   s_axis_tdata,   // vertex_index
    input  logic                          s_axis_tlast,   // end_of_draw
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [pa_pkg::DATA_W-1:0]     m_axis_tdata,   // corner_a, corner_b, corner_c
    output logic [pa_pkg::KIND_W-1:0]     m_axis_tuser,   // prim_kind
    output logic                          m_axis_tlast    // run_last
);
    import pa_pkg::*;

    typedef logic [INDEX_BITS-1:0] idx_t;

    typedef struct packed {
        logic  en;
        kind_t kind;
        idx_t  a;
        idx_t  b;
        idx_t  c;
    } prim_t;

    typedef struct packed {
        kind_t kind;
        idx_t  a;
        idx_t  b;
        idx_t  c;
        logic  last;
    } entry_t;

    localparam int QDEPTH = 3;

    // configuration
    mode_t                mode_reg;
    logic [COUNT_W-1:0]   vcount_reg;

    // draw state
    logic [PHASE_W-1:0]   phase_reg, phase_next;
    logic [WARM_W-1:0]    warm_reg, warm_next;
    idx_t                 p0_reg, p1_reg, p2_reg;
    idx_t                 p0_next, p1_next, p2_next;
    idx_t                 first_reg, first_next;

    // result queue, entry zero drives the master side
    entry_t               q_reg [QDEPTH];
    entry_t               q_next [QDEPTH];
    logic [1:0]           count_reg, count_next;

    logic                 in_xfer;
    logic                 out_xfer;
    idx_t                 cur;
    idx_t                 first;
    prim_t                r0, r1;
    entry_t               slot0, slot1;
    logic [1:0]           push_n;
    logic [1:0]           base;

    function automatic logic ok(idx_t v, logic [COUNT_W-1:0] n);
        return COUNT_W'(v) < n;
    endfunction

    function automatic prim_t mk_point(idx_t a, logic [COUNT_W-1:0] n);
        prim_t p;
        p.en   = ok(a, n);
        p.kind = KIND_POINT;
        p.a    = a;
        p.b    = '0;
        p.c    = '0;
        return p;
    endfunction

    function automatic prim_t mk_line(idx_t a, idx_t b, logic [COUNT_W-1:0] n);
        prim_t p;
        p.en   = ok(a, n) && ok(b, n);
        p.kind = KIND_LINE;
        p.a    = a;
        p.b    = b;
        p.c    = '0;
        return p;
    endfunction

    function automatic prim_t mk_tri(idx_t a, idx_t b, idx_t c, logic [COUNT_W-1:0] n);
        prim_t p;
        p.en   = ok(a, n) && ok(b, n) && ok(c, n);
        p.kind = KIND_TRIANGLE;
        p.a    = a;
        p.b    = b;
        p.c    = c;
        return p;
    endfunction

    assign cur           = s_axis_tdata[INDEX_BITS-1:0];
    assign first         = (warm_reg == '0) ? cur : first_reg;
    assign s_axis_tready = (count_reg <= 2'd1);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (count_reg != '0);
    assign out_xfer      = m_axis_tvalid && m_axis_tready;

    // primitives made by the incoming index
    always_comb
    begin
        r0 = '0;
        r1 = '0;
        unique case (mode_reg)
            MODE_POINTS:
            begin
                r0 = mk_point(cur, vcount_reg);
            end
            MODE_LINES:
            begin
                if (phase_reg[0])
                    r0 = mk_line(p0_reg, cur, vcount_reg);
            end
            MODE_LINE_LOOP:
            begin
                if (warm_reg != '0)
                begin
                    r0 = mk_line(p0_reg, cur, vcount_reg);
                    // closing line back to the first index
                    if (s_axis_tlast)
                        r1 = mk_line(cur, first, vcount_reg);
                end
            end
            MODE_LINE_STRIP:
            begin
                if (warm_reg != '0)
                    r0 = mk_line(p0_reg, cur, vcount_reg);
            end
            MODE_TRIS:
            begin
                case (phase_reg) inside
                    4'd2, 4'd5, 4'd8, 4'd11: r0 = mk_tri(p1_reg, p0_reg, cur, vcount_reg);
                    default: ;
                endcase
            end
            MODE_TRI_STRIP:
            begin
                if (warm_reg[1])
                    r0 = mk_tri(p1_reg, p0_reg, cur, vcount_reg);
            end
            MODE_TRI_FAN, MODE_POLYGON:
            begin
                if (warm_reg[1])
                    r0 = mk_tri(first, p0_reg, cur, vcount_reg);
            end
            MODE_QUADS:
            begin
                case (phase_reg) inside
                    4'd3, 4'd7, 4'd11:
                    begin
                        r0 = mk_tri(p2_reg, p1_reg, p0_reg, vcount_reg);
                        r1 = mk_tri(p2_reg, p0_reg, cur, vcount_reg);
                    end
                    default: ;
                endcase
            end
            MODE_QUAD_STRIP:
            begin
                // reordered to i, i+1, i+3, i+2
                if ((warm_reg == 2'd3) && phase_reg[0])
                begin
                    r0 = mk_tri(p2_reg, p1_reg, cur, vcount_reg);
                    r1 = mk_tri(p2_reg, cur, p0_reg, vcount_reg);
                end
            end
            default: ;
        endcase
    end

    // compact the enabled primitives into queue entries
    always_comb
    begin
        slot0 = '{kind: r0.kind, a: r0.a, b: r0.b, c: r0.c, last: !r1.en};
        slot1 = '{kind: r1.kind, a: r1.a, b: r1.b, c: r1.c, last: 1'b1};
        if (!r0.en)
            slot0 = slot1;
        push_n = in_xfer ? ({1'b0, r0.en} + {1'b0, r1.en}) : 2'd0;
    end

    // queue update: shift on transfer out, append behind the remaining entries
    always_comb
    begin
        for (int i = 0; i < QDEPTH; i++)
        begin
            if (out_xfer && (i < QDEPTH - 1))
                q_next[i] = q_reg[i+1];
            else
                q_next[i] = q_reg[i];
        end
        base = count_reg - {1'b0, out_xfer};
        for (int i = 0; i < QDEPTH; i++)
        begin
            if ((push_n != '0) && (2'(i) == base))
                q_next[i] = slot0;
            if ((push_n == 2'd2) && (2'(i) == base + 2'd1))
                q_next[i] = slot1;
        end
        count_next = base + push_n;
    end

    always_comb
    begin
        phase_next = phase_reg;
        warm_next  = warm_reg;
        p0_next    = p0_reg;
        p1_next    = p1_reg;
        p2_next    = p2_reg;
        first_next = first_reg;
        if (in_xfer)
        begin
            if (s_axis_tlast)
            begin
                phase_next = '0;
                warm_next  = '0;
                p0_next    = '0;
                p1_next    = '0;
                p2_next    = '0;
                first_next = '0;
            end
            else
            begin
                phase_next = (phase_reg == PHASE_WRAP) ? '0 : phase_reg + 4'd1;
                warm_next  = (warm_reg == 2'd3) ? warm_reg : warm_reg + 2'd1;
                p0_next    = cur;
                p1_next    = p0_reg;
                p2_next    = p1_reg;
                first_next = first;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_POINTS;
            vcount_reg <= '0;
            phase_reg  <= '0;
            warm_reg   <= '0;
            p0_reg     <= '0;
            p1_reg     <= '0;
            p2_reg     <= '0;
            first_reg  <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    REG_PRIM_MODE:    mode_reg   <= mode_t'(cfg_wdata[MODE_W-1:0]);
                    REG_VERTEX_COUNT: vcount_reg <= cfg_wdata[COUNT_W-1:0];
                    default: ;
                endcase
            end
            phase_reg <= phase_next;
            warm_reg  <= warm_next;
            p0_reg    <= p0_next;
            p1_reg    <= p1_next;
            p2_reg    <= p2_next;
            first_reg <= first_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QDEPTH; i++)
            q_reg[i] <= q_next[i];
    end

    assign m_axis_tdata = {CORNER_W'(q_reg[0].c), CORNER_W'(q_reg[0].b), CORNER_W'(q_reg[0].a)};
    assign m_axis_tuser = q_reg[0].kind;
    assign m_axis_tlast = q_reg[0].last;

endmodule

/* hw/rtl/pa_checker.sv */
// port-level checks for the primitive assembly master side, bound to the top
// level; depends on pa_pkg
module pa_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      m_axis_tvalid,
    input logic                      m_axis_tready,
    input logic [pa_pkg::DATA_W-1:0] m_axis_tdata,
    input logic [pa_pkg::KIND_W-1:0] m_axis_tuser,
    input logic                      m_axis_tlast
);
    import pa_pkg::*;

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // points carry only the first corner
    a_point_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_POINT) |->
            (m_axis_tdata[DATA_W-1:CORNER_W] == '0))
        else $error("point with nonzero second or third corner");

    // lines leave the third corner zero
    a_line_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_LINE) |->
            (m_axis_tdata[DATA_W-1:2*CORNER_W] == '0))
        else $error("line with nonzero third corner");

endmodule

bind primitive_assembly pa_checker u_pa_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
